/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the jitter buffer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a trigger is followed by a result in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ajb_pkg.sv */
// ----------------------------------------------------------------------------
// ajb_pkg
// Types and constants shared by the jitter buffer modules.
// ----------------------------------------------------------------------------
package ajb_pkg;

    // Ring geometry
    localparam int RING_DEPTH   = 1024;
    localparam int CHUNK_FRAMES = 64;
    localparam int ADDR_W       = $clog2(RING_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int CHUNK_W      = $clog2(CHUNK_FRAMES + 1);

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int FILL_W    = 11;
    localparam int PEAK_W    = 15;
    localparam int PREFILL_W = 11;
    localparam int CMP_W     = (CNT_W > PREFILL_W) ? CNT_W : PREFILL_W;

    localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

    // Actions
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_PULL = 2'd1;
    localparam logic [1:0] ACT_PEAK = 2'd2;

    // Configuration port
    localparam int                    PADDR_W      = 3;
    localparam int                    PDATA_W      = 32;
    localparam logic [PADDR_W-3:0]    REG_PREFILL  = '0;
    localparam logic [PREFILL_W-1:0]  PREFILL_RST  = 11'd256;

    typedef struct packed {
        logic [1:0]                 action;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       player_idle;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       sample_valid;
        logic                       last_of_chunk;
        logic                       dropped_oldest;
        logic [FILL_W-1:0]          fill_count;
        logic                       is_primed;
        logic [PEAK_W-1:0]          peak_value;
    } t_out_word;

endpackage

/* sv/ajb_ram.sv */
// ----------------------------------------------------------------------------
// ajb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ajb_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/ajb_cfg.sv */
// ----------------------------------------------------------------------------
// ajb_cfg
// APB register block holding the prefill level.
// ----------------------------------------------------------------------------
module ajb_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ajb_pkg::PADDR_W-1:0]    paddr,
    input  logic [ajb_pkg::PDATA_W-1:0]    pwdata,
    output logic [ajb_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    output logic [ajb_pkg::PREFILL_W-1:0]  o_prefill_level
);

    logic [ajb_pkg::PREFILL_W-1:0] r_prefill;
    logic                          sel_prefill;

    assign sel_prefill = (paddr[ajb_pkg::PADDR_W-1:2] == ajb_pkg::REG_PREFILL);

    // Write the prefill level on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefill <= ajb_pkg::PREFILL_RST;
        end else if (psel && penable && pwrite && sel_prefill) begin
            r_prefill <= pwdata[ajb_pkg::PREFILL_W-1:0];
        end
    end

    // Read back, zero outside the register map
    assign prdata = sel_prefill ? ajb_pkg::PDATA_W'(r_prefill) : '0;
    assign pready = 1'b1;

    assign o_prefill_level = r_prefill;

endmodule

/* sv/audio_jitter_buffer_prefill.sv */
// ----------------------------------------------------------------------------
// audio_jitter_buffer_prefill
// Drop-oldest ring jitter buffer for 16-bit audio with prefill and peak meter.
// ----------------------------------------------------------------------------
// A push, a peak read or an unknown action returns one word; a new word is
// taken every cycle as long as the output side keeps up.
// A pull that finds the buffer primed and holding a full chunk streams
// CHUNK_FRAMES samples out of the ring through the single read port of the
// sample RAM, one per cycle while the output does not stall, and holds the
// input off while the chunk streams; any other pull returns one empty word at once.
// The sample RAM needs no clearing pass after reset: only held entries are
// ever read. The user must write the prefill level over the APB port only while
// idle; the block itself does not enforce it.
module audio_jitter_buffer_prefill (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  ajb_pkg::t_in_word             i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output ajb_pkg::t_out_word            o_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ajb_pkg::PADDR_W-1:0]   paddr,
    input  logic [ajb_pkg::PDATA_W-1:0]   pwdata,
    output logic [ajb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_STREAM = 2'b10
    } t_state;

    // Control and buffer state
    t_state                          r_state, n_state;
    logic [ajb_pkg::ADDR_W-1:0]      r_rp, n_rp;
    logic [ajb_pkg::CNT_W-1:0]       r_held, n_held;
    logic                            r_primed, n_primed;
    logic [ajb_pkg::PEAK_W-1:0]      r_peak, n_peak;

    // Streaming read side
    logic [ajb_pkg::ADDR_W-1:0]      r_rd_addr, n_rd_addr;
    logic [ajb_pkg::CHUNK_W-1:0]     r_issued, n_issued;
    logic                            r_pend, n_pend;
    logic                            r_pend_last, n_pend_last;

    // Output register and skid stage
    logic                            r_out_valid, n_out_valid;
    ajb_pkg::t_out_word              r_out, n_out;
    logic                            r_skid_valid, n_skid_valid;
    logic [ajb_pkg::SAMPLE_W-1:0]    r_skid_smp, n_skid_smp;
    logic                            r_skid_last, n_skid_last;

    logic [ajb_pkg::PREFILL_W-1:0]   prefill_level;
    logic                            in_acc;
    logic                            out_take;
    logic                            issue;
    logic                            start_stream;
    logic [1:0]                      occ_eff;
    logic [ajb_pkg::SAMPLE_W-1:0]    neg_smp;
    logic [ajb_pkg::PEAK_W-1:0]      mag;
    logic [ajb_pkg::SAMPLE_W-1:0]    rd_data;
    logic                            wr_en;
    logic [ajb_pkg::ADDR_W-1:0]      wr_addr;
    logic                            prime_now;
    logic                            drop;
    logic [ajb_pkg::CNT_W-1:0]       held_push;

    // Configuration registers
    ajb_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_prefill_level (prefill_level)
    );

    // Sample ring
    ajb_ram #(
        .DEPTH (ajb_pkg::RING_DEPTH),
        .WIDTH (ajb_pkg::SAMPLE_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data.sample_in),
        .i_rd_en   (issue),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshakes
    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && (!r_out_valid || !i_stall));
    assign in_acc   = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // Magnitude of the incoming sample, saturated
    assign neg_smp = ajb_pkg::SAMPLE_W'(0) - i_data.sample_in;
    always_comb begin
        if (!i_data.sample_in[ajb_pkg::SAMPLE_W-1]) begin
            mag = i_data.sample_in[ajb_pkg::PEAK_W-1:0];
        end else if (neg_smp[ajb_pkg::SAMPLE_W-1]) begin
            mag = ajb_pkg::PEAK_MAX;
        end else begin
            mag = neg_smp[ajb_pkg::PEAK_W-1:0];
        end
    end

    // Push write: old pointer on a drop, since the dropped slot is reused
    assign drop      = (r_held == ajb_pkg::CNT_W'(ajb_pkg::RING_DEPTH));
    assign wr_addr   = r_rp + r_held[ajb_pkg::ADDR_W-1:0];
    assign wr_en     = in_acc && (i_data.action == ajb_pkg::ACT_PUSH);
    assign held_push = drop ? r_held : r_held + ajb_pkg::CNT_W'(1);

    // Prime check at the start of a pull
    assign prime_now = r_primed ||
        (ajb_pkg::CMP_W'(r_held) >= ajb_pkg::CMP_W'(prefill_level));
    assign start_stream = in_acc && (i_data.action == ajb_pkg::ACT_PULL) && prime_now &&
        (r_held >= ajb_pkg::CNT_W'(ajb_pkg::CHUNK_FRAMES));

    // Issue a read while the output register and skid have room
    assign occ_eff = 2'(r_out_valid) + 2'(r_skid_valid) + 2'(r_pend) - 2'(out_take);
    assign issue   = (r_state == S_STREAM) &&
        (r_issued != ajb_pkg::CHUNK_W'(ajb_pkg::CHUNK_FRAMES)) && (occ_eff < 2'd2);

    always_comb begin
        n_state      = r_state;
        n_rp         = r_rp;
        n_held       = r_held;
        n_primed     = r_primed;
        n_peak       = r_peak;
        n_rd_addr    = r_rd_addr;
        n_issued     = r_issued;
        n_pend       = issue;
        n_pend_last  = (r_issued == ajb_pkg::CHUNK_W'(ajb_pkg::CHUNK_FRAMES - 1));
        n_out_valid  = r_out_valid && !out_take;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid_smp   = r_skid_smp;
        n_skid_last  = r_skid_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out                = '0;
                    n_out.last_of_chunk  = 1'b1;
                    n_out_valid          = 1'b1;
                    unique case (i_data.action)
                        ajb_pkg::ACT_PUSH: begin
                            // Store, drop oldest when full, track peak
                            if (mag > r_peak) begin
                                n_peak = mag;
                            end
                            if (drop) begin
                                n_rp = r_rp + ajb_pkg::ADDR_W'(1);
                            end
                            n_held = held_push;
                            n_primed = r_primed || (ajb_pkg::CMP_W'(held_push) >=
                                ajb_pkg::CMP_W'(prefill_level));
                            n_out.dropped_oldest = drop;
                            n_out.fill_count     = ajb_pkg::FILL_W'(held_push);
                            n_out.is_primed      = n_primed;
                        end
                        ajb_pkg::ACT_PULL: begin
                            n_primed = prime_now;
                            if (start_stream) begin
                                // Hand the chunk to the read side
                                n_held      = r_held - ajb_pkg::CNT_W'(ajb_pkg::CHUNK_FRAMES);
                                n_rp        = r_rp + ajb_pkg::ADDR_W'(ajb_pkg::CHUNK_FRAMES);
                                n_rd_addr   = r_rp;
                                n_issued    = '0;
                                n_state     = S_STREAM;
                                n_out       = r_out;
                                n_out_valid = r_out_valid && !out_take;
                            end
                            if (prime_now && i_data.player_idle &&
                                (n_held < ajb_pkg::CNT_W'(ajb_pkg::CHUNK_FRAMES))) begin
                                n_primed = 1'b0;
                            end
                            n_out.fill_count = ajb_pkg::FILL_W'(n_held);
                            n_out.is_primed  = n_primed;
                        end
                        ajb_pkg::ACT_PEAK: begin
                            // Report and clear the peak
                            n_peak             = '0;
                            n_out.peak_value   = r_peak;
                            n_out.fill_count   = ajb_pkg::FILL_W'(r_held);
                            n_out.is_primed    = r_primed;
                        end
                        default: begin
                            n_out.fill_count = ajb_pkg::FILL_W'(r_held);
                            n_out.is_primed  = r_primed;
                        end
                    endcase
                end
            end
            S_STREAM: begin
                if (issue) begin
                    n_rd_addr = r_rd_addr + ajb_pkg::ADDR_W'(1);
                    n_issued  = r_issued + ajb_pkg::CHUNK_W'(1);
                end
                // Move skid and returning read data toward the output
                n_out.sample_valid   = 1'b1;
                n_out.dropped_oldest = 1'b0;
                n_out.fill_count     = ajb_pkg::FILL_W'(r_held);
                n_out.is_primed      = r_primed;
                n_out.peak_value     = '0;
                if (!r_out_valid || out_take) begin
                    if (r_skid_valid) begin
                        n_out.sample_out    = r_skid_smp;
                        n_out.last_of_chunk = r_skid_last;
                        n_out_valid         = 1'b1;
                        n_skid_valid        = r_pend;
                        n_skid_smp          = rd_data;
                        n_skid_last         = r_pend_last;
                    end else if (r_pend) begin
                        n_out.sample_out    = rd_data;
                        n_out.last_of_chunk = r_pend_last;
                        n_out_valid         = 1'b1;
                    end else begin
                        n_out_valid = 1'b0;
                    end
                end else begin
                    n_out = r_out;
                    if (r_pend) begin
                        n_skid_valid = 1'b1;
                        n_skid_smp   = rd_data;
                        n_skid_last  = r_pend_last;
                    end
                end
                if ((n_issued == ajb_pkg::CHUNK_W'(ajb_pkg::CHUNK_FRAMES)) &&
                    !n_pend && !n_skid_valid) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rp         <= '0;
            r_held       <= '0;
            r_primed     <= 1'b0;
            r_peak       <= '0;
            r_issued     <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rp         <= n_rp;
            r_held       <= n_held;
            r_primed     <= n_primed;
            r_peak       <= n_peak;
            r_issued     <= n_issued;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr   <= n_rd_addr;
        r_pend_last <= n_pend_last;
        r_out       <= n_out;
        r_skid_smp  <= n_skid_smp;
        r_skid_last <= n_skid_last;
    end

    `ASSERT_ALWAYS(a_skid_behind_out, i_clk, i_rst_n, !r_skid_valid || r_out_valid,
        "skid holds a word while the output register is empty")
    `ASSERT_ALWAYS(a_no_overbook, i_clk, i_rst_n, !(r_out_valid && r_skid_valid && r_pend),
        "read returned with output and skid both full")
    `ASSERT_ALWAYS(a_held_bound, i_clk, i_rst_n,
        r_held <= ajb_pkg::CNT_W'(ajb_pkg::RING_DEPTH), "fill count beyond ring depth")
    `ASSERT_NEXT(a_stream_start, i_clk, i_rst_n, start_stream,
        (r_state == S_STREAM) && (r_issued == '0), "chunk pull did not start streaming")

endmodule

/* tb/jitter_buffer_checker.sv */
// ----------------------------------------------------------------------------
// jitter_buffer_checker
// Tracks the jitter buffer's ring, fill, prime flag and peak meter from the
// words taken on the input channel and the writes on the APB port, and checks
// every word leaving the output channel, field by field, in order.
// ----------------------------------------------------------------------------
module jitter_buffer_checker
    import ajb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_word             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_word            i_out_data,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [PADDR_W-1:0]   i_paddr,
    input  logic [PDATA_W-1:0]   i_pwdata,
    input  logic [PDATA_W-1:0]   i_prdata,
    input  logic                 i_pready,
    output int                   o_errors,
    output int                   o_owed
);

    // Shadow copy of the buffer state
    logic [SAMPLE_W-1:0]  ring [RING_DEPTH];
    logic [ADDR_W-1:0]    rd_ptr;
    logic [CNT_W-1:0]     held;
    logic                 primed;
    logic [PEAK_W-1:0]    peak;
    logic [PREFILL_W-1:0] prefill;

    t_out_word owed_words [$];
    int        err_cnt = 0;

    wire apb_access = i_psel && i_penable && i_pready && (i_paddr[PADDR_W-1:2] == REG_PREFILL);

    // Build a word that carries the fill and prime state as they stand now
    function automatic t_out_word status_word(logic [SAMPLE_W-1:0] smp, logic vld,
                                              logic last, logic drop,
                                              logic [PEAK_W-1:0] pk);
        t_out_word w;
        w.sample_out     = smp;
        w.sample_valid   = vld;
        w.last_of_chunk  = last;
        w.dropped_oldest = drop;
        w.fill_count     = held;
        w.is_primed      = primed;
        w.peak_value     = pk;
        return w;
    endfunction

    function automatic void mark_primed();
        if (!primed && held >= prefill) begin
            primed = 1'b1;
        end
    endfunction

    // Advance the shadow state by one input word and queue the words it owes
    function automatic void take_word(t_in_word w);
        int                  mag;
        int                  n;
        logic                drop;
        logic [PEAK_W-1:0]   pk;
        logic [SAMPLE_W-1:0] chunk [CHUNK_FRAMES];
        n = 0;
        case (w.action)
            ACT_PUSH: begin
                mag = int'(w.sample_in);
                if (mag < 0) begin
                    mag = -mag;
                end
                if (mag > int'(PEAK_MAX)) begin
                    mag = int'(PEAK_MAX);
                end
                if (mag > int'(peak)) begin
                    peak = PEAK_W'(mag);
                end
                // Full ring: drop the oldest sample first
                drop = 1'b0;
                if (held >= CNT_W'(RING_DEPTH)) begin
                    rd_ptr = rd_ptr + 1'b1;
                    held   = CNT_W'(RING_DEPTH - 1);
                    drop   = 1'b1;
                end
                ring[ADDR_W'(rd_ptr + held)] = w.sample_in;
                held = held + 1'b1;
                mark_primed();
                owed_words.push_back(status_word('0, 1'b0, 1'b1, drop, '0));
            end
            ACT_PULL: begin
                mark_primed();
                if (primed && held >= CNT_W'(CHUNK_FRAMES)) begin
                    for (int k = 0; k < CHUNK_FRAMES; k++) begin
                        chunk[k] = ring[rd_ptr];
                        rd_ptr   = rd_ptr + 1'b1;
                    end
                    held = held - CNT_W'(CHUNK_FRAMES);
                    n    = CHUNK_FRAMES;
                end
                // Unprime on underrun while the player has gone idle
                if (primed && held < CNT_W'(CHUNK_FRAMES) && w.player_idle) begin
                    primed = 1'b0;
                end
                if (n == 0) begin
                    owed_words.push_back(status_word('0, 1'b0, 1'b1, 1'b0, '0));
                end
                for (int k = 0; k < n; k++) begin
                    owed_words.push_back(status_word(chunk[k], 1'b1, k == n - 1, 1'b0, '0));
                end
            end
            ACT_PEAK: begin
                pk   = peak;
                peak = '0;
                owed_words.push_back(status_word('0, 1'b0, 1'b1, 1'b0, pk));
            end
            default: begin
                owed_words.push_back(status_word('0, 1'b0, 1'b1, 1'b0, '0));
            end
        endcase
    endfunction

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic void check_word(t_out_word got);
        t_out_word want;
        if (owed_words.size() == 0) begin
            $error("output word with nothing expected: %p", got);
            err_cnt++;
        end else begin
            want = owed_words.pop_front();
            compare_field("sample_out", longint'(want.sample_out), longint'(got.sample_out));
            compare_field("sample_valid", want.sample_valid, got.sample_valid);
            compare_field("last_of_chunk", want.last_of_chunk, got.last_of_chunk);
            compare_field("dropped_oldest", want.dropped_oldest, got.dropped_oldest);
            compare_field("fill_count", want.fill_count, got.fill_count);
            compare_field("is_primed", want.is_primed, got.is_primed);
            compare_field("peak_value", want.peak_value, got.peak_value);
        end
    endfunction

    // Follow both channels and the register port every cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_ptr  = '0;
            held    = '0;
            primed  = 1'b0;
            peak    = '0;
            prefill = PREFILL_RST;
            owed_words.delete();
        end else begin
            if (apb_access && !i_pwrite) begin
                compare_field("prefill_level readback", longint'(prefill), longint'(i_prdata));
            end
            if (apb_access && i_pwrite) begin
                prefill = i_pwdata[PREFILL_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                take_word(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                check_word(i_out_data);
            end
        end
        o_owed   <= owed_words.size();
        o_errors <= err_cnt;
    end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the jitter buffer with directed and random pushes, pulls and peak
// reads under several prefill levels, with random gaps and stalls on both
// channels, and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module testbench;
    import ajb_pkg::*;

    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT   = 1000000;
    localparam int         SETTLE_CYCLES = CHUNK_FRAMES + 16;
    localparam int         MAX_WAIT      = 13;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    t_in_word            i_data;
    logic                o_valid;
    logic                i_stall;
    t_out_word           o_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int errors;
    int owed;
    int cycle_cnt = 0;
    bit tx_quiet  = 1'b0;

    audio_jitter_buffer_prefill u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    jitter_buffer_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_data  (o_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_errors    (errors),
        .o_owed      (owed)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_in_word make_word(logic [1:0] act, logic [SAMPLE_W-1:0] smp,
                                           logic idle);
        t_in_word w;
        w.action      = act;
        w.sample_in   = smp;
        w.player_idle = idle;
        return w;
    endfunction

    // Mostly uniform samples, with the full-scale, minus-one and zero values mixed in
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        logic [SAMPLE_W-1:0] s;
        s = SAMPLE_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: s = 16'h7FFF;
                1: s = 16'h8000;
                2: s = 16'hFFFF;
                default: s = '0;
            endcase
        end
        return s;
    endfunction

    function automatic t_in_word rand_word();
        int          pick;
        logic [1:0]  act;
        pick = $urandom_range(0, 99);
        if (pick < 68) begin
            act = ACT_PUSH;
        end else if (pick < 88) begin
            act = ACT_PULL;
        end else if (pick < 96) begin
            act = ACT_PEAK;
        end else begin
            act = ACT_UNUSED;
        end
        return make_word(act, rand_sample(), 1'($urandom_range(0, 1)));
    endfunction

    // Offer one word after a random gap and hold it until it is taken
    task automatic send_word(t_in_word w);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Hold off the input until every owed word has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (owed != 0);
    endtask

    // Write the prefill level, then read it back
    task automatic set_prefill(logic [PREFILL_W-1:0] lvl);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PREFILL, 2'b00};
        pwdata  <= PDATA_W'(lvl);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Output side: hold the stall for a random wait ahead of each word, none in quiet runs
    initial begin : rx_side
        int  waits;
        int  run_len;
        bit  rx_quiet;
        run_len  = 0;
        rx_quiet = 1'b0;
        i_stall <= 1'b0;
        repeat (10) @(posedge i_clk);
        forever begin
            if (run_len == 0) begin
                rx_quiet = ($urandom_range(0, 3) == 0);
                run_len  = $urandom_range(20, 120);
            end
            waits = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (waits > 0) begin
                i_stall <= 1'b1;
                repeat (waits) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            run_len--;
        end
    end

    initial begin : stimulus
        logic [PREFILL_W-1:0] levels [6];
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset prefill: full-scale pushes, saturated magnitude, peak clear
        send_word(make_word(ACT_PUSH, 16'h7FFF, 1'b0));
        send_word(make_word(ACT_PUSH, 16'h8000, 1'b1));
        send_word(make_word(ACT_PEAK, 16'hFFFF, 1'b0));
        send_word(make_word(ACT_PEAK, 16'h0000, 1'b1));
        send_word(make_word(ACT_PUSH, 16'hFFFF, 1'b0));
        send_word(make_word(ACT_PUSH, 16'h0000, 1'b0));
        send_word(make_word(ACT_PULL, 16'h5555, 1'b0));
        send_word(make_word(ACT_UNUSED, 16'hAAAA, 1'b1));
        wait_drained();

        // Prefill of one: primes with a short ring, unprimes on idle
        set_prefill(11'd1);
        send_word(make_word(ACT_PULL, 16'h0000, 1'b0));
        send_word(make_word(ACT_PULL, 16'h0000, 1'b1));
        send_word(make_word(ACT_PUSH, 16'h0001, 1'b0));
        send_word(make_word(ACT_PEAK, 16'h0000, 1'b0));
        wait_drained();

        // Prefill of zero: primed at the first check
        set_prefill(11'd0);
        send_word(make_word(ACT_PULL, 16'h0000, 1'b0));
        send_word(make_word(ACT_PUSH, 16'h8001, 1'b0));
        send_word(make_word(ACT_PULL, 16'h0000, 1'b1));
        wait_drained();

        // Prefill beyond the ring depth: never primes
        set_prefill(11'h7FF);
        send_word(make_word(ACT_PUSH, 16'h1234, 1'b0));
        send_word(make_word(ACT_PUSH, 16'hEDCB, 1'b1));
        send_word(make_word(ACT_PULL, 16'h0000, 1'b0));
        send_word(make_word(ACT_PULL, 16'h0000, 1'b1));
        wait_drained();

        // Random phases, each a fill run followed by mixed traffic
        levels = '{11'd64, 11'($urandom_range(1, 128)), 11'd1, 11'd0,
                   11'h7FF, PREFILL_RST};
        foreach (levels[p]) begin
            wait_drained();
            set_prefill(levels[p]);
            tx_quiet = ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(20, 30)) begin
                send_word(make_word(ACT_PUSH, rand_sample(), 1'($urandom_range(0, 1))));
            end
            repeat (10) begin
                send_word(rand_word());
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
